// ===== design/tpbm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers of the triple packet buffer manager
// no dependencies; imported by every module of the block

package tpbm_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int BUF_BYTES   = 65536;
    localparam int NBANKS      = 3;
    localparam int ALIGN_BYTES = 16;

    // item field widths
    localparam int OP_W     = 2;
    localparam int LEN_W    = 16;
    localparam int IDX_W    = 6;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 2;
    localparam int OFFS_W   = 16;
    localparam int OCNT_W   = 7;
    localparam int OUSED_W  = 17;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 80;

    // configuration port
    localparam int CFG_MAXPK_W = 7;
    localparam int CFG_BUF_W   = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 1;

    // internal widths
    localparam int CNT_W     = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int USED_W    = $clog2(BUF_BYTES + 1);
    localparam int NEED_W    = LEN_W + 1;
    localparam int SUM_W     = ((USED_W > NEED_W) ? USED_W : NEED_W) + 1;
    localparam int MEM_DEPTH = NBANKS * MAX_ENTRIES;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    typedef logic [1:0] t_bank;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_NEXT   = 2'd1,
        OP_ROTATE = 2'd2,
        OP_MARK   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_PACKETS = 1'd0,
        REG_BUFFER_SIZE = 1'd1
    } t_reg;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch the accepted item
        logic step;     // move the output read position past a dropped entry
        logic exec;     // carry out the op and load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic skip;      // next op sits on a dropped entry
        logic out_free;  // result register can take a new item
    } t_stat;

    // memory address of an entry: bank base plus position
    function automatic logic [ADDR_W-1:0] slot_addr(t_bank bank, logic [POS_W-1:0] pos);
        logic [ADDR_W-1:0] base;
        case (bank)
            2'd0:    base = '0;
            2'd1:    base = ADDR_W'(MAX_ENTRIES);
            default: base = ADDR_W'(2 * MAX_ENTRIES);
        endcase
        return base + ADDR_W'(pos);
    endfunction

endpackage

// ===== design/tpbm_ctrl.sv =====
`timescale 1ns / 1ps
// controller of the triple packet buffer manager: accept, execute, skip walk
// depends on tpbm_pkg

module tpbm_ctrl import tpbm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_s_tvalid,
    output logic   o_s_tready,
    input  t_stat  i_stat,
    output t_cmd   o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // walk over dropped entries one at a time before the result
                if (i_stat.skip) begin
                    o_cmd.step = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_s_tvalid) |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execution");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.step && o_cmd.exec))
        else $error("skip step and execute issued together");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && i_stat.skip) |=> (r_state == S_EXEC))
        else $error("left execution while on a dropped entry");

endmodule

// ===== design/tpbm_datapath.sv =====
`timescale 1ns / 1ps
// datapath of the triple packet buffer manager: bank registers, descriptor
// memories, configuration registers and result register; depends on tpbm_pkg

module tpbm_datapath import tpbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    // op[1:0], length[17:2], index[23:18], tag[31:24], invalid[32]
    input  logic [S_DATA_W-1:0]   i_s_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    // status[1:0], offset[17:2], length_out[33:18], tag_out[41:34],
    // in_count[48:42], in_used[65:49], out_left[72:66], in_full[73]
    output logic [M_DATA_W-1:0]   o_m_tdata
);

    // configuration
    logic [CFG_MAXPK_W-1:0] r_max_packets;
    logic [CFG_BUF_W-1:0]   r_buffer_size;

    // latched item
    t_op               r_op;
    logic [LEN_W-1:0]  r_len;
    logic [IDX_W-1:0]  r_idx;
    logic [TAG_W-1:0]  r_tag;
    logic              r_inval;

    // bank state
    logic [CNT_W-1:0]  r_count [NBANKS];
    logic [USED_W-1:0] r_used  [NBANKS];
    logic [CNT_W-1:0]  r_rdpos [NBANKS];
    t_bank             r_in_bank, r_out_bank, r_mid_bank;
    logic [CNT_W-1:0]  n_count [NBANKS];
    logic [USED_W-1:0] n_used  [NBANKS];
    logic [CNT_W-1:0]  n_rdpos [NBANKS];
    t_bank             n_in_bank, n_out_bank, n_mid_bank;

    // descriptor memories
    logic [OFFS_W+LEN_W-1:0] r_mem_ol   [MEM_DEPTH];
    logic [TAG_W-1:0]        r_mem_tag  [MEM_DEPTH];
    logic                    r_mem_drop [MEM_DEPTH];
    logic [OFFS_W+LEN_W-1:0] r_rd_ol;
    logic [TAG_W-1:0]        r_rd_tag;
    logic                    r_rd_drop;
    logic                    we_ol, we_tag, we_drop;
    logic [ADDR_W-1:0]       waddr, raddr;
    logic [OFFS_W+LEN_W-1:0] wdata_ol;
    logic [TAG_W-1:0]        wdata_tag;
    logic                    wdata_drop;

    // result register
    logic                  r_out_valid;
    logic [M_DATA_W-1:0]   r_m_tdata;
    t_status               res_status;
    logic [OFFS_W-1:0]     res_offset;
    logic [LEN_W-1:0]      res_length;
    logic [TAG_W-1:0]      res_tag;

    // limits and append arithmetic
    logic [CFG_MAXPK_W-1:0] lim_cnt;
    logic [CFG_BUF_W-1:0]   lim_bytes;
    logic [NEED_W-1:0]      need;
    logic [SUM_W-1:0]       sum;
    logic                   in_is_full;
    logic                   has_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_packets <= CFG_MAXPK_W'(64);
            r_buffer_size <= CFG_BUF_W'(65536);
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_MAX_PACKETS: r_max_packets <= i_cfg_wdata[CFG_MAXPK_W-1:0];
                REG_BUFFER_SIZE: r_buffer_size <= i_cfg_wdata[CFG_BUF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_s_tdata[1:0]);
            r_len   <= i_s_tdata[17:2];
            r_idx   <= i_s_tdata[23:18];
            r_tag   <= i_s_tdata[31:24];
            r_inval <= i_s_tdata[32];
        end
    end

    always_comb begin
        lim_cnt   = (32'(r_max_packets) < MAX_ENTRIES) ? r_max_packets
                                                      : CFG_MAXPK_W'(MAX_ENTRIES);
        lim_bytes = (32'(r_buffer_size) < BUF_BYTES) ? r_buffer_size
                                                    : CFG_BUF_W'(BUF_BYTES);
        // round up to 16 bytes, a zero length still takes one block
        if (r_len == '0) begin
            need = NEED_W'(ALIGN_BYTES);
        end else begin
            need = (NEED_W'(r_len) + NEED_W'(ALIGN_BYTES - 1))
                   & ~NEED_W'(ALIGN_BYTES - 1);
        end
        sum        = SUM_W'(r_used[r_in_bank]) + SUM_W'(need);
        in_is_full = 32'(r_count[r_in_bank]) >= 32'(lim_cnt);
        has_entry  = r_rdpos[r_out_bank] < r_count[r_out_bank];
    end

    assign o_stat.skip     = (r_op == OP_NEXT) && has_entry && r_rd_drop;
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_count    = r_count;
        n_used     = r_used;
        n_rdpos    = r_rdpos;
        n_in_bank  = r_in_bank;
        n_out_bank = r_out_bank;
        n_mid_bank = r_mid_bank;
        we_ol      = 1'b0;
        we_tag     = 1'b0;
        we_drop    = 1'b0;
        waddr      = slot_addr(r_in_bank, r_count[r_in_bank][POS_W-1:0]);
        wdata_ol   = {r_len, r_used[r_in_bank][OFFS_W-1:0]};
        wdata_tag  = '0;
        wdata_drop = 1'b0;
        res_status = ST_OK;
        res_offset = '0;
        res_length = '0;
        res_tag    = '0;

        if (i_cmd.step) begin
            n_rdpos[r_out_bank] = r_rdpos[r_out_bank] + CNT_W'(1);
        end

        if (i_cmd.exec) begin
            case (r_op)
                OP_APPEND: begin
                    if (in_is_full) begin
                        res_status = ST_FULL;
                    end else if (sum > SUM_W'(lim_bytes)) begin
                        res_status = ST_NOSPACE;
                    end else begin
                        we_ol   = 1'b1;
                        we_tag  = 1'b1;
                        we_drop = 1'b1;
                        res_offset = r_used[r_in_bank][OFFS_W-1:0];
                        res_length = r_len;
                        n_used[r_in_bank]  = sum[USED_W-1:0];
                        n_count[r_in_bank] = r_count[r_in_bank] + CNT_W'(1);
                    end
                end
                OP_NEXT: begin
                    if (!has_entry) begin
                        res_status = ST_EMPTY;
                    end else begin
                        res_offset = r_rd_ol[OFFS_W-1:0];
                        res_length = r_rd_ol[OFFS_W+LEN_W-1:OFFS_W];
                        res_tag    = r_rd_tag;
                        n_rdpos[r_out_bank] = r_rdpos[r_out_bank] + CNT_W'(1);
                    end
                end
                OP_ROTATE: begin
                    n_out_bank          = r_mid_bank;
                    n_mid_bank          = r_in_bank;
                    n_in_bank           = r_out_bank;
                    n_count[r_out_bank] = '0;
                    n_used[r_out_bank]  = '0;
                    n_rdpos[r_out_bank] = '0;
                end
                default: begin
                    // mark beyond the middle bank count is ignored
                    waddr      = slot_addr(r_mid_bank, r_idx[POS_W-1:0]);
                    wdata_tag  = r_tag;
                    wdata_drop = 1'b1;
                    if (32'(r_idx) < 32'(r_count[r_mid_bank])) begin
                        we_drop = r_inval;
                        we_tag  = !r_inval;
                    end
                end
            endcase
        end

        // keep the read data on the entry at the output read position
        raddr = slot_addr(n_out_bank, n_rdpos[n_out_bank][POS_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NBANKS; b++) begin
                r_count[b] <= '0;
                r_used[b]  <= '0;
                r_rdpos[b] <= '0;
            end
            r_in_bank  <= 2'd0;
            r_out_bank <= 2'd1;
            r_mid_bank <= 2'd2;
        end else begin
            r_count    <= n_count;
            r_used     <= n_used;
            r_rdpos    <= n_rdpos;
            r_in_bank  <= n_in_bank;
            r_out_bank <= n_out_bank;
            r_mid_bank <= n_mid_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_ol) begin
            r_mem_ol[waddr] <= wdata_ol;
        end
        r_rd_ol <= r_mem_ol[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we_tag) begin
            r_mem_tag[waddr] <= wdata_tag;
        end
        r_rd_tag <= r_mem_tag[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we_drop) begin
            r_mem_drop[waddr] <= wdata_drop;
        end
        r_rd_drop <= r_mem_drop[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_m_tdata <= {6'b0,
                          32'(n_count[n_in_bank]) >= 32'(lim_cnt),
                          OCNT_W'(n_count[n_out_bank] - n_rdpos[n_out_bank]),
                          OUSED_W'(n_used[n_in_bank]),
                          OCNT_W'(n_count[n_in_bank]),
                          res_tag,
                          res_length,
                          res_offset,
                          res_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_m_tdata;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_bank != r_out_bank) && (r_in_bank != r_mid_bank)
        && (r_out_bank != r_mid_bank))
        else $error("bank roles overlap");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rdpos[r_out_bank] <= r_count[r_out_bank])
        else $error("output read position beyond bank count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> !(r_out_valid && !i_m_tready))
        else $error("result register overwritten while held");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_ROTATE) |=>
        (r_count[r_in_bank] == '0) && (r_used[r_in_bank] == '0))
        else $error("new input bank not cleared by rotate");

endmodule

// ===== design/triple_packet_buffer_manager.sv =====
`timescale 1ns / 1ps
// Triple packet buffer manager: three descriptor banks rotating through the
// input, middle and output roles. One op item in, one result item out. An
// item is taken in the idle state and executed in the execute state. A next
// first steps over each dropped entry it meets before its result, since the
// descriptor memory gives one registered read per cycle. The result sits in
// an output register; execution waits only if that register still holds an
// untaken result. The user must write configuration through the plain write
// port only while idle; the block itself does not enforce this.
// Depends on tpbm_pkg, tpbm_ctrl and tpbm_datapath.

module triple_packet_buffer_manager import tpbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // op[1:0], length[17:2], index[23:18], tag[31:24], invalid[32]
    input  logic [S_DATA_W-1:0]   s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[1:0], offset[17:2], length_out[33:18], tag_out[41:34],
    // in_count[48:42], in_used[65:49], out_left[72:66], in_full[73]
    output logic [M_DATA_W-1:0]   m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    tpbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tpbm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench of triple_packet_buffer_manager: stream ops in, results out
// depends on tpbm_pkg and the block; keeps its own copy of the three descriptor banks

module testbench;
    import tpbm_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 80;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 80;

    typedef struct packed {
        logic       invalid;
        logic [7:0] tag;
        logic [5:0] index;
        logic [15:0] length;
        t_op        op;
    } t_op_item;

    typedef struct packed {
        logic        in_full;
        logic [6:0]  out_left;
        logic [16:0] in_used;
        logic [6:0]  in_count;
        logic [7:0]  tag;
        logic [15:0] len;
        logic [15:0] offset;
        t_status     status;
    } t_result;

    typedef enum bit {ROW_OP, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_op_item    it;
        bit          typed;
        t_result     want;
        t_reg        reg_sel;
        int unsigned value;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    triple_packet_buffer_manager i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the banks and registers
    logic [15:0] ent_offset  [NBANKS][MAX_ENTRIES];
    logic [15:0] ent_length  [NBANKS][MAX_ENTRIES];
    logic [7:0]  ent_tag     [NBANKS][MAX_ENTRIES];
    bit          ent_dropped [NBANKS][MAX_ENTRIES];
    int unsigned bank_cnt[NBANKS]   = '{0, 0, 0};
    int unsigned bank_bytes[NBANKS] = '{0, 0, 0};
    int unsigned bank_rd[NBANKS]    = '{0, 0, 0};
    int unsigned in_b = 0, out_b = 1, mid_b = 2;
    int unsigned cfg_max_packets = 64;
    int unsigned cfg_buffer_size = 65536;

    t_result pending_results[$];
    t_row    dir_rows[$];

    int fail_count = 0;
    int cycle_count = 0;
    int n_append = 0, n_refused = 0, n_next = 0, n_empty = 0;
    int n_rotate = 0, n_mark = 0, n_writes = 0, n_checked = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;

    function automatic t_result apply_buffer_op(t_op_item it);
        t_result     r;
        int unsigned lim_cnt, lim_bytes, need, b, pos;
        r = '0;
        r.status = ST_OK;
        lim_cnt = (cfg_max_packets < MAX_ENTRIES) ? cfg_max_packets : MAX_ENTRIES;
        lim_bytes = (cfg_buffer_size < BUF_BYTES) ? cfg_buffer_size : BUF_BYTES;
        case (it.op)
            OP_APPEND: begin
                b = in_b;
                n_append++;
                // zero length still takes one aligned chunk
                need = (it.length == 0) ? ALIGN_BYTES :
                       (int'(it.length) + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
                if (bank_cnt[b] >= lim_cnt) begin
                    r.status = ST_FULL;
                end else if (bank_bytes[b] + need > lim_bytes) begin
                    r.status = ST_NOSPACE;
                end else begin
                    pos = bank_cnt[b];
                    ent_offset[b][pos] = 16'(bank_bytes[b]);
                    ent_length[b][pos] = it.length;
                    ent_tag[b][pos] = '0;
                    ent_dropped[b][pos] = 1'b0;
                    r.offset = 16'(bank_bytes[b]);
                    r.len = it.length;
                    bank_bytes[b] += need;
                    bank_cnt[b]++;
                end
                if (r.status != ST_OK) n_refused++;
            end
            OP_NEXT: begin
                b = out_b;
                n_next++;
                while (bank_rd[b] < bank_cnt[b] && ent_dropped[b][bank_rd[b]]) bank_rd[b]++;
                if (bank_rd[b] >= bank_cnt[b]) begin
                    r.status = ST_EMPTY;
                    n_empty++;
                end else begin
                    r.offset = ent_offset[b][bank_rd[b]];
                    r.len = ent_length[b][bank_rd[b]];
                    r.tag = ent_tag[b][bank_rd[b]];
                    bank_rd[b]++;
                end
            end
            OP_ROTATE: begin
                n_rotate++;
                b = out_b;
                out_b = mid_b;
                mid_b = in_b;
                in_b = b;
                bank_cnt[in_b] = 0;
                bank_bytes[in_b] = 0;
                bank_rd[in_b] = 0;
            end
            OP_MARK: begin
                n_mark++;
                if (it.index < bank_cnt[mid_b]) begin
                    if (it.invalid) ent_dropped[mid_b][it.index] = 1'b1;
                    else ent_tag[mid_b][it.index] = it.tag;
                end
            end
        endcase
        r.in_count = 7'(bank_cnt[in_b]);
        r.in_used = 17'(bank_bytes[in_b]);
        r.out_left = 7'(bank_cnt[out_b] - bank_rd[out_b]);
        r.in_full = (bank_cnt[in_b] >= lim_cnt);
        return r;
    endfunction

    function automatic t_result res(t_status st, int unsigned off, int unsigned len,
                                    int unsigned tg, int unsigned cnt, int unsigned used,
                                    int unsigned left, bit full);
        t_result r;
        r.status = st;
        r.offset = 16'(off);
        r.len = 16'(len);
        r.tag = 8'(tg);
        r.in_count = 7'(cnt);
        r.in_used = 17'(used);
        r.out_left = 7'(left);
        r.in_full = full;
        return r;
    endfunction

    function automatic t_row op_row(t_op op, int unsigned len, int unsigned idx,
                                    int unsigned tg, bit inv);
        t_row row;
        row.kind = ROW_OP;
        row.it.op = op;
        row.it.length = 16'(len);
        row.it.index = 6'(idx);
        row.it.tag = 8'(tg);
        row.it.invalid = inv;
        row.typed = 1'b0;
        row.want = '0;
        row.reg_sel = REG_MAX_PACKETS;
        row.value = 0;
        return row;
    endfunction

    function automatic t_row chk_row(t_op op, int unsigned len, int unsigned idx,
                                     int unsigned tg, bit inv, t_result want);
        t_row row;
        row = op_row(op, len, idx, tg, inv);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic t_row cfg_row(t_reg r, int unsigned v);
        t_row row;
        row = op_row(OP_APPEND, 0, 0, 0, 1'b0);
        row.kind = ROW_CFG;
        row.reg_sel = r;
        row.value = v;
        return row;
    endfunction

    function automatic t_op_item random_item();
        t_op_item    it;
        int unsigned pick;
        it.length = 16'($urandom);
        it.index = 6'($urandom);
        it.tag = 8'($urandom);
        it.invalid = 1'($urandom);
        pick = $urandom_range(99);
        if (pick < 40) begin
            it.op = OP_APPEND;
            pick = $urandom_range(9);
            // mostly short packets so banks fill by count as well as by bytes
            if (pick < 7) it.length = 16'($urandom_range(255));
            else if (pick < 9) it.length = 16'($urandom_range(4095));
        end else if (pick < 65) begin
            it.op = OP_NEXT;
        end else if (pick < 75) begin
            it.op = OP_ROTATE;
        end else begin
            it.op = OP_MARK;
            if (bank_cnt[mid_b] > 0 && $urandom_range(9) < 8)
                it.index = 6'($urandom_range(bank_cnt[mid_b] - 1));
            it.invalid = ($urandom_range(9) < 4);
        end
        return it;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_item(t_op_item it, bit typed, t_result want);
        int      gap;
        t_result got;
        gap = tx_idle ? $urandom_range(6) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= S_DATA_W'(it);
        do @(posedge i_clk); while (!s_axis_tready);
        got = apply_buffer_op(it);
        pending_results.push_back(typed ? want : got);
    endtask

    task automatic hold_sender();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results_drained(int extra);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg r, int unsigned v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= r;
        i_cfg_wdata <= CFG_DATA_W'(v);
        @(posedge i_clk);
        if (r == REG_MAX_PACKETS) cfg_max_packets = v & 32'h7f;
        else cfg_buffer_size = v & 32'h1ffff;
        n_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("status", want.status, got.status);
                check_field("offset", want.offset, got.offset);
                check_field("length_out", want.len, got.len);
                check_field("tag_out", want.tag, got.tag);
                check_field("in_count", want.in_count, got.in_count);
                check_field("in_used", want.in_used, got.in_used);
                check_field("out_left", want.out_left, got.out_left);
                check_field("in_full", want.in_full, got.in_full);
            end
        end
    end

    // result side: random stall before each item in phases with rx_idle set
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = rx_idle ? $urandom_range(6) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        int unsigned mp_set[PHASES] = '{64, 5, 1, 127, 64, 40, 0, 0};
        int unsigned bs_set[PHASES] = '{65536, 4096, 16, 131071, 800, 2000, 0, 0};

        // op, length, index, tag, invalid
        dir_rows.push_back(chk_row(OP_NEXT, 0, 0, 0, 0, res(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0)));
        dir_rows.push_back(chk_row(OP_APPEND, 0, 0, 0, 0, res(ST_OK, 0, 0, 0, 1, 16, 0, 0)));
        dir_rows.push_back(chk_row(OP_APPEND, 65535, 0, 0, 0,
                                   res(ST_NOSPACE, 0, 0, 0, 1, 16, 0, 0)));
        dir_rows.push_back(chk_row(OP_APPEND, 1, 0, 0, 0, res(ST_OK, 16, 1, 0, 2, 32, 0, 0)));
        dir_rows.push_back(op_row(OP_APPEND, 17, 63, 255, 1));
        dir_rows.push_back(op_row(OP_APPEND, 16, 0, 0, 0));
        dir_rows.push_back(op_row(OP_ROTATE, 65535, 63, 255, 1));
        dir_rows.push_back(op_row(OP_MARK, 0, 0, 0, 1));
        dir_rows.push_back(op_row(OP_MARK, 65535, 1, 255, 0));
        dir_rows.push_back(op_row(OP_MARK, 0, 63, 170, 0));
        dir_rows.push_back(op_row(OP_MARK, 0, 3, 85, 1));
        dir_rows.push_back(chk_row(OP_APPEND, 65535, 0, 0, 0,
                                   res(ST_OK, 0, 65535, 0, 1, 65536, 0, 0)));
        dir_rows.push_back(chk_row(OP_APPEND, 0, 0, 0, 0,
                                   res(ST_NOSPACE, 0, 0, 0, 1, 65536, 0, 0)));
        dir_rows.push_back(op_row(OP_ROTATE, 0, 0, 0, 0));
        dir_rows.push_back(op_row(OP_NEXT, 0, 0, 0, 0));
        dir_rows.push_back(op_row(OP_NEXT, 0, 0, 0, 0));
        dir_rows.push_back(op_row(OP_NEXT, 0, 0, 0, 0));
        dir_rows.push_back(op_row(OP_NEXT, 65535, 63, 255, 1));
        dir_rows.push_back(cfg_row(REG_MAX_PACKETS, 1));
        dir_rows.push_back(chk_row(OP_APPEND, 100, 0, 0, 0, res(ST_OK, 0, 100, 0, 1, 112, 0, 1)));
        dir_rows.push_back(chk_row(OP_APPEND, 5, 0, 0, 0, res(ST_FULL, 0, 0, 0, 1, 112, 0, 1)));
        dir_rows.push_back(cfg_row(REG_MAX_PACKETS, 0));
        dir_rows.push_back(chk_row(OP_APPEND, 0, 0, 0, 0, res(ST_FULL, 0, 0, 0, 1, 112, 0, 1)));
        dir_rows.push_back(cfg_row(REG_BUFFER_SIZE, 0));
        dir_rows.push_back(cfg_row(REG_MAX_PACKETS, 127));
        dir_rows.push_back(op_row(OP_ROTATE, 0, 0, 0, 0));
        dir_rows.push_back(chk_row(OP_APPEND, 0, 0, 0, 0,
                                   res(ST_NOSPACE, 0, 0, 0, 0, 0, 1, 0)));
        dir_rows.push_back(cfg_row(REG_BUFFER_SIZE, 131071));
        dir_rows.push_back(op_row(OP_APPEND, 65535, 0, 0, 0));
        dir_rows.push_back(op_row(OP_NEXT, 0, 0, 0, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                hold_sender();
                wait_results_drained(SETTLE_CYCLES);
                write_register(dir_rows[i].reg_sel, dir_rows[i].value);
            end else begin
                send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            // registers only change once every result is back
            hold_sender();
            wait_results_drained(SETTLE_CYCLES);
            if (phase >= PHASES - 2) begin
                mp_set[phase] = $urandom_range(127);
                bs_set[phase] = $urandom_range(131071);
            end
            write_register(REG_MAX_PACKETS, mp_set[phase]);
            write_register(REG_BUFFER_SIZE, bs_set[phase]);
            tx_idle = (phase % 3 != 2);
            rx_idle = (phase % 4 != 3);
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), 1'b0, '0);
        end

        hold_sender();
        wait_results_drained(TAIL_CYCLES);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end
        $display("ops sent: %0d appends (%0d refused), %0d nexts (%0d empty), %0d rotates, %0d marks",
                 n_append, n_refused, n_next, n_empty, n_rotate, n_mark);
        $display("%0d register writes, %0d results checked, %0d failures",
                 n_writes, n_checked, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/tpbm_pkg.sv
design/tpbm_ctrl.sv
design/tpbm_datapath.sv
design/triple_packet_buffer_manager.sv
test/testbench.sv
